FILE: design/hhvf_pkg.sv
package hhvf_pkg;

  localparam int NAME_CHARS   = 8;
  localparam int VALUE_BUFFER = 512;

  localparam logic [63:0] HEADER_NAME_RST   = 64'h6E6F_6974_6163_6F4C; // "Location"
  localparam logic [3:0]  NAME_LENGTH_RST   = 4'd8;
  localparam logic [8:0]  MAX_VALUE_LEN_RST = 9'd511;

  localparam logic [3:0] NAME_CAP = 4'(NAME_CHARS);
  localparam logic [8:0] VALUE_CAP = (VALUE_BUFFER - 1 > 511) ? 9'd511 : 9'(VALUE_BUFFER - 1);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] CFG_HEADER_NAME   = 2'd0;
  localparam logic [1:0] CFG_NAME_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_MAX_VALUE_LEN = 2'd2;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_MATCH,
    PH_SKIPWS,
    PH_COPY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_value;
    logic       found;
    logic       last;
  } result_t;

  // up to two results produced by one byte, slot 0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c inside {[8'h41:8'h5A]}) begin
      f = c + 8'h20;
    end
    return f;
  endfunction

endpackage

FILE: design/hhvf_scan.sv
module hhvf_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  input  logic [63:0]         header_name,
  input  logic [3:0]          name_length,
  input  logic [8:0]          max_value_len,
  output hhvf_pkg::push_t     push
);

  hhvf_pkg::phase_t phase_r, phase_nxt, ph;
  logic       at_line_start_r, at_line_start_nxt;
  logic [3:0] match_count_r, match_count_nxt, mc;
  logic [8:0] copied_count_r, copied_count_nxt;
  logic       header_found_r, header_found_nxt;

  logic [3:0] nlen;
  logic [8:0] lim;
  logic [7:0] name_ch;
  logic       eol;
  logic       take;
  hhvf_pkg::result_t val_res, sum_res;

  assign nlen = (name_length > hhvf_pkg::NAME_CAP) ? hhvf_pkg::NAME_CAP : name_length;
  assign lim  = (max_value_len > hhvf_pkg::VALUE_CAP) ? hhvf_pkg::VALUE_CAP : max_value_len;
  assign eol  = (data_byte == hhvf_pkg::CH_CR) || (data_byte == hhvf_pkg::CH_LF);

  // while seeking, a new line restarts the name compare
  always_comb begin
    if (phase_r == hhvf_pkg::PH_SEEK && at_line_start_r) begin
      ph = hhvf_pkg::PH_MATCH;
      mc = 4'd0;
    end else begin
      ph = phase_r;
      mc = match_count_r;
    end
  end

  assign name_ch = header_name[{mc[2:0], 3'b000} +: 8];

  always_comb begin
    phase_nxt        = ph;
    match_count_nxt  = mc;
    copied_count_nxt = copied_count_r;
    header_found_nxt = header_found_r;
    take             = 1'b0;
    case (ph)
      hhvf_pkg::PH_MATCH: begin
        if (mc < nlen) begin
          if (data_byte != hhvf_pkg::CH_LF &&
              hhvf_pkg::fold_case(data_byte) == hhvf_pkg::fold_case(name_ch)) begin
            match_count_nxt = mc + 4'd1;
          end else begin
            phase_nxt = hhvf_pkg::PH_SEEK;
          end
        end else if (data_byte == hhvf_pkg::CH_COLON) begin
          header_found_nxt = 1'b1;
          phase_nxt        = hhvf_pkg::PH_SKIPWS;
        end else begin
          phase_nxt = hhvf_pkg::PH_SEEK;
        end
      end
      hhvf_pkg::PH_SKIPWS: begin
        if (data_byte == hhvf_pkg::CH_SPACE || data_byte == hhvf_pkg::CH_TAB) begin
          phase_nxt = hhvf_pkg::PH_SKIPWS;
        end else if (eol) begin
          phase_nxt = hhvf_pkg::PH_DONE;
        end else begin
          phase_nxt = hhvf_pkg::PH_COPY;
          take      = (copied_count_r < lim);
        end
      end
      hhvf_pkg::PH_COPY: begin
        if (eol) begin
          phase_nxt = hhvf_pkg::PH_DONE;
        end else begin
          take = (copied_count_r < lim);
        end
      end
      default: begin
      end
    endcase
    if (take) begin
      copied_count_nxt = copied_count_r + 9'd1;
    end
    at_line_start_nxt = (data_byte == hhvf_pkg::CH_LF);
    if (end_of_buffer) begin
      phase_nxt         = hhvf_pkg::PH_SEEK;
      at_line_start_nxt = 1'b1;
      match_count_nxt   = 4'd0;
      copied_count_nxt  = 9'd0;
      header_found_nxt  = 1'b0;
    end
  end

  always_comb begin
    val_res.value_byte = data_byte;
    val_res.is_value   = 1'b1;
    val_res.found      = 1'b1;
    val_res.last       = 1'b0;
    sum_res.value_byte = 8'd0;
    sum_res.is_value   = 1'b0;
    // found is taken after this byte's update, so a colon on the last byte counts
    sum_res.found      = header_found_nxt | (header_found_r & ~end_of_buffer) |
                         (end_of_buffer & (header_found_r |
                          (ph == hhvf_pkg::PH_MATCH && mc >= nlen &&
                           data_byte == hhvf_pkg::CH_COLON)));
    sum_res.last       = 1'b1;
    push.r0 = take ? val_res : sum_res;
    push.r1 = sum_res;
    push.n  = step ? ({1'b0, take} + {1'b0, end_of_buffer}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= hhvf_pkg::PH_SEEK;
      at_line_start_r <= 1'b1;
      match_count_r   <= 4'd0;
      copied_count_r  <= 9'd0;
      header_found_r  <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      at_line_start_r <= at_line_start_nxt;
      match_count_r   <= match_count_nxt;
      copied_count_r  <= copied_count_nxt;
      header_found_r  <= header_found_nxt;
    end
  end

endmodule

FILE: design/hhvf_out_fifo.sv
module hhvf_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  hhvf_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              not_empty,
  output hhvf_pkg::result_t head
);

  hhvf_pkg::result_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  assign not_empty = (count_r != 3'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop & not_empty;
  // two free slots must be there for a byte that yields a value and a summary
  assign room      = (count_r <= 3'd2) || (count_r == 3'd3 && do_pop);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, push.n} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/http_header_value_finder_unit.sv
// HTTP header value finder
// Bytes of a response enter on the in_ channel (in_data_byte, in_end_of_buffer),
// one per request. The first line whose name matches header_name (case folded,
// name_length chars, then a colon) has its value streamed on the out_ channel
// with out_is_value high. The byte flagged end_of_buffer also yields a summary
// (out_is_value low, out_found set if the header was found, out_last high) after
// any value byte of that byte, and the scan starts over.
// Registers are written on the cfg_ channel (index 0 name, 1 length, 2 limit),
// which is always ready; write them only while the block is idle.
// Throughput is one byte per cycle while the result queue has room. A byte is held
// in the input register until the queue has room, then evaluated, and its results
// are written into a four-entry result queue that drives the out_ ports. A byte
// that yields two results needs two free queue slots.
// When the receiver stalls, the queue fills and in_ready drops; nothing is lost.
// Synchronous reset clears the scan state and the queue and restores the
// register defaults ("Location", 8, 511).
module http_header_value_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_value_byte,
  output logic        out_is_value,
  output logic        out_found,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] header_name_r;
  logic [3:0]  name_length_r;
  logic [8:0]  max_value_len_r;

  logic        in_vld_r;
  logic [7:0]  data_byte_r;
  logic        end_of_buffer_r;

  logic              room;
  logic              step;
  hhvf_pkg::push_t   push;
  hhvf_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign step      = in_vld_r & room;
  assign in_ready  = ~in_vld_r | step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_name_r   <= hhvf_pkg::HEADER_NAME_RST;
      name_length_r   <= hhvf_pkg::NAME_LENGTH_RST;
      max_value_len_r <= hhvf_pkg::MAX_VALUE_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        hhvf_pkg::CFG_HEADER_NAME:   header_name_r   <= cfg_data;
        hhvf_pkg::CFG_NAME_LENGTH:   name_length_r   <= cfg_data[3:0];
        hhvf_pkg::CFG_MAX_VALUE_LEN: max_value_len_r <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_byte_r     <= in_data_byte;
      end_of_buffer_r <= in_end_of_buffer;
    end
  end

  hhvf_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (data_byte_r),
    .end_of_buffer (end_of_buffer_r),
    .header_name   (header_name_r),
    .name_length   (name_length_r),
    .max_value_len (max_value_len_r),
    .push          (push)
  );

  hhvf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_value_byte = head.value_byte;
  assign out_is_value   = head.is_value;
  assign out_found      = head.found;
  assign out_last       = head.last;

endmodule

FILE: tb/hhvf_checker.sv
`timescale 1ns / 1ps
module hhvf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_value_byte,
  input  logic        out_is_value,
  input  logic        out_found,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic [31:0] mismatches,
  output logic [31:0] outstanding
);

  // shadow copy of the registers
  logic [63:0] name_reg;
  logic [3:0]  len_reg;
  logic [8:0]  limit_reg;

  // scan state
  hhvf_pkg::phase_t scan_phase;
  logic   line_start;
  int     matched;
  int     copied;
  logic   seen_header;

  hhvf_pkg::result_t expected_results[$];

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic clear_scan();
    scan_phase  = hhvf_pkg::PH_SEEK;
    line_start  = 1'b1;
    matched     = 0;
    copied      = 0;
    seen_header = 1'b0;
  endtask

  task automatic add_value(input logic [7:0] b);
    int limit;
    hhvf_pkg::result_t r;
    limit = (limit_reg > hhvf_pkg::VALUE_BUFFER - 1) ? hhvf_pkg::VALUE_BUFFER - 1
                                                      : int'(limit_reg);
    // bytes past the limit are dropped without a result
    if (copied < limit) begin
      copied = copied + 1;
      r.value_byte = b;
      r.is_value   = 1'b1;
      r.found      = 1'b1;
      r.last       = 1'b0;
      expected_results.push_back(r);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eob);
    int nlen;
    logic eol;
    hhvf_pkg::result_t s;
    nlen = (len_reg > hhvf_pkg::NAME_CHARS) ? hhvf_pkg::NAME_CHARS : int'(len_reg);
    eol  = (b == hhvf_pkg::CH_CR) || (b == hhvf_pkg::CH_LF);
    if (scan_phase == hhvf_pkg::PH_SEEK && line_start) begin
      scan_phase = hhvf_pkg::PH_MATCH;
      matched    = 0;
    end
    case (scan_phase)
      hhvf_pkg::PH_MATCH: begin
        if (matched < nlen) begin
          // a line feed always breaks the compare
          if (b != hhvf_pkg::CH_LF &&
              lower_ascii(b) == lower_ascii(name_reg[8*matched +: 8])) begin
            matched = matched + 1;
          end else begin
            scan_phase = hhvf_pkg::PH_SEEK;
          end
        end else if (b == hhvf_pkg::CH_COLON) begin
          seen_header = 1'b1;
          scan_phase  = hhvf_pkg::PH_SKIPWS;
        end else begin
          scan_phase = hhvf_pkg::PH_SEEK;
        end
      end
      hhvf_pkg::PH_SKIPWS: begin
        if (b != hhvf_pkg::CH_SPACE && b != hhvf_pkg::CH_TAB) begin
          if (eol) begin
            scan_phase = hhvf_pkg::PH_DONE;
          end else begin
            scan_phase = hhvf_pkg::PH_COPY;
            add_value(b);
          end
        end
      end
      hhvf_pkg::PH_COPY: begin
        if (eol) begin
          scan_phase = hhvf_pkg::PH_DONE;
        end else begin
          add_value(b);
        end
      end
      default: begin
      end
    endcase
    line_start = (b == hhvf_pkg::CH_LF);
    if (eob) begin
      s.value_byte = 8'h00;
      s.is_value   = 1'b0;
      s.found      = seen_header;
      s.last       = 1'b1;
      expected_results.push_back(s);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin : watch
    hhvf_pkg::result_t want;
    if (!rst_n) begin
      name_reg   = hhvf_pkg::HEADER_NAME_RST;
      len_reg    = hhvf_pkg::NAME_LENGTH_RST;
      limit_reg  = hhvf_pkg::MAX_VALUE_LEN_RST;
      mismatches = 0;
      expected_results.delete();
      clear_scan();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result byte %02h is_value %0b found %0b last %0b",
                                  out_value_byte, out_is_value, out_found, out_last));
        end else begin
          want = expected_results.pop_front();
          if (out_value_byte !== want.value_byte || out_is_value !== want.is_value ||
              out_found !== want.found || out_last !== want.last) begin
            note_mismatch($sformatf({"got byte %02h is_value %0b found %0b last %0b, ",
                                     "expected byte %02h is_value %0b found %0b last %0b"},
                                    out_value_byte, out_is_value, out_found, out_last,
                                    want.value_byte, want.is_value, want.found, want.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hhvf_pkg::CFG_HEADER_NAME:   name_reg  = cfg_data;
          hhvf_pkg::CFG_NAME_LENGTH:   len_reg   = cfg_data[3:0];
          hhvf_pkg::CFG_MAX_VALUE_LEN: limit_reg = cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        scan_byte(in_data_byte, in_end_of_buffer);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int RANDOM_PHASES  = 8;
  localparam int CYCLE_LIMIT    = 1500000;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [7:0]  in_data_byte     = 8'h00;
  logic        in_end_of_buffer = 1'b0;
  logic        out_ready        = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic [1:0]  cfg_index        = hhvf_pkg::CFG_HEADER_NAME;
  logic [63:0] cfg_data         = 64'h0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_value_byte;
  logic        out_is_value;
  logic        out_found;
  logic        out_last;
  logic        cfg_ready;

  logic [31:0] mismatches;
  logic [31:0] outstanding;

  int          cycles     = 0;
  int          sent       = 0;
  int          stall_left = 0;
  bit          no_idle    = 1'b0;

  logic [7:0]  response_bytes[$];
  logic [63:0] cur_name     = hhvf_pkg::HEADER_NAME_RST;
  logic [3:0]  cur_name_len = hhvf_pkg::NAME_LENGTH_RST;

  http_header_value_finder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_byte   (out_value_byte),
    .out_is_value     (out_is_value),
    .out_found        (out_found),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hhvf_checker finder_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_byte   (out_value_byte),
    .out_is_value     (out_is_value),
    .out_found        (out_found),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // hold the request until accepted, then maybe idle
  task automatic push_byte(input logic [7:0] b, input logic eob);
    int gap;
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    sent = sent + 1;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_buffer();
    for (int i = 0; i < response_bytes.size(); i++) begin
      push_byte(response_bytes[i], i == response_bytes.size() - 1);
    end
    response_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // a byte with no result may still be in flight
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] nm, input logic [3:0] len,
                            input logic [8:0] lim);
    logic [63:0] junk;
    wait_drained();
    junk = {$urandom, $urandom};
    write_reg(hhvf_pkg::CFG_HEADER_NAME, nm);
    write_reg(hhvf_pkg::CFG_NAME_LENGTH, {junk[63:4], len});
    write_reg(hhvf_pkg::CFG_MAX_VALUE_LEN, {junk[63:9], lim});
    cur_name     = nm;
    cur_name_len = len;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      response_bytes.push_back(s[i]);
    end
  endtask

  // optional blanks, then a value with no line end in it
  task automatic add_value_text(input int max_len);
    logic [7:0] c;
    repeat ($urandom_range(3, 0)) begin
      response_bytes.push_back($urandom_range(1, 0) ? hhvf_pkg::CH_SPACE : hhvf_pkg::CH_TAB);
    end
    repeat ($urandom_range(max_len, 0)) begin
      if ($urandom_range(4, 0) != 0) begin
        c = 8'($urandom_range(126, 32));
      end else begin
        c = 8'($urandom_range(255, 0));
        if (c == hhvf_pkg::CH_CR || c == hhvf_pkg::CH_LF) c = 8'h2E;
      end
      response_bytes.push_back(c);
    end
  endtask

  task automatic build_response();
    int r;
    int n;
    int nlen;
    int keep;
    logic [7:0] c;
    response_bytes.delete();
    nlen = (cur_name_len > hhvf_pkg::NAME_CHARS) ? hhvf_pkg::NAME_CHARS : int'(cur_name_len);
    repeat ($urandom_range(6, 1)) begin
      r = $urandom_range(99, 0);
      if (r < 50) begin
        // the configured name in scrambled case, sometimes cut short or broken
        n = (r < 40) ? nlen : $urandom_range(nlen, 0);
        for (int k = 0; k < n; k++) begin
          c = cur_name[8*k +: 8];
          if (((c | 8'h20) inside {[8'h61:8'h7A]}) && $urandom_range(1, 0)) begin
            c = c ^ 8'h20;
          end
          response_bytes.push_back(c);
        end
        response_bytes.push_back((r < 40) ? hhvf_pkg::CH_COLON : 8'($urandom_range(255, 0)));
        add_value_text(12);
      end else if (r < 85) begin
        repeat ($urandom_range(10, 1)) begin
          response_bytes.push_back($urandom_range(1, 0) ? 8'($urandom_range(90, 65))
                                                        : 8'($urandom_range(122, 97)));
        end
        response_bytes.push_back(hhvf_pkg::CH_COLON);
        add_value_text(15);
      end else begin
        repeat ($urandom_range(10, 1)) begin
          response_bytes.push_back(8'($urandom_range(255, 0)));
        end
      end
      r = $urandom_range(9, 0);
      if (r < 7) begin
        response_bytes.push_back(hhvf_pkg::CH_CR);
        response_bytes.push_back(hhvf_pkg::CH_LF);
      end else if (r < 9) begin
        response_bytes.push_back(hhvf_pkg::CH_LF);
      end else begin
        response_bytes.push_back(hhvf_pkg::CH_CR);
      end
    end
    // buffer that ends in the middle of a line
    if ($urandom_range(9, 0) == 0) begin
      keep = $urandom_range(response_bytes.size(), 1);
      while (response_bytes.size() > keep) void'(response_bytes.pop_back());
    end
  endtask

  initial begin
    logic [63:0] nm;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mixed-case name, blanks skipped, last byte carries a value byte
    add_text("LoCaTiOn:");
    response_bytes.push_back(hhvf_pkg::CH_TAB);
    add_text(" ab");
    send_buffer();

    // empty name: a leading colon matches, here on the last byte
    set_config(hhvf_pkg::HEADER_NAME_RST, 4'd0, 9'd511);
    add_text(":");
    send_buffer();
    response_bytes.push_back(8'hFF);
    send_buffer();
    response_bytes.push_back(8'h00);
    send_buffer();

    // line feed inside the name never matches
    set_config(64'h0A68, 4'd2, 9'd1);
    add_text("h");
    response_bytes.push_back(hhvf_pkg::CH_LF);
    add_text(":");
    send_buffer();

    // value cut at the limit, bytes after the value ignored
    set_config(64'h68, 4'd1, 9'd1);
    add_text("H:xy");
    response_bytes.push_back(hhvf_pkg::CH_CR);
    add_text("z");
    send_buffer();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(hhvf_pkg::HEADER_NAME_RST, 4'd8, 9'd511);
        1: set_config(64'h7473_6F48, 4'd4, 9'd0);
        2: begin
          for (int k = 0; k < 8; k++) begin
            nm[8*k +: 8] = 8'($urandom_range(25, 0)) + ($urandom_range(1, 0) ? 8'h41 : 8'h61);
          end
          set_config(nm, 4'd15, 9'd3);
        end
        3: set_config(64'h6449_2D58, 4'd0, 9'd5);
        4: set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 9'd511);
        5: set_config(64'h0, 4'd3, 9'd2);
        default: set_config({$urandom, $urandom}, 4'($urandom_range(15, 0)),
                            9'($urandom_range(511, 0)));
      endcase
      if (p == 0) begin
        // one value longer than the block can hold
        add_text("location: ");
        repeat (515) response_bytes.push_back(8'($urandom_range(126, 33)));
        response_bytes.push_back(hhvf_pkg::CH_CR);
        response_bytes.push_back(hhvf_pkg::CH_LF);
        send_buffer();
      end
      while (sent < DIRECTED_ITEMS + (p + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        no_idle = ($urandom_range(4, 0) == 0);
        build_response();
        send_buffer();
        if ($urandom_range(7, 0) == 0) wait_drained();
      end
      no_idle = 1'b0;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/hhvf_pkg.sv
design/hhvf_scan.sv
design/hhvf_out_fifo.sv
design/http_header_value_finder_unit.sv
tb/hhvf_checker.sv
tb/tb.sv
